@@ rtl/rts_pkg.sv @@
package rts_pkg;

	// cordic step count and fixed constants
	localparam int STEPS = 28;
	localparam logic [22:0] RIGHT_Q16 = 23'd5898240;
	localparam logic [30:0] ONE_Q30 = 31'd1073741824;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

	// atan(2^-i) in degrees with 24 fraction bits
	localparam logic [29:0] STEP_DEG [STEPS] = '{
		30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
		30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
		30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671, 30'd29335,
		30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229,
		30'd115, 30'd57, 30'd29, 30'd14, 30'd7
	};

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FEW    = 2'd1;
	localparam logic [1:0] ST_DOMAIN = 2'd2;

	// which known pair drives the solution
	typedef enum logic [2:0] {
		MODE_AB, MODE_AC, MODE_BC, MODE_AA, MODE_BB, MODE_CA, MODE_CB, MODE_FEW
	} mode_t;

	typedef struct packed {
		logic [31:0] leg_a;
		logic        leg_a_given;
		logic [31:0] leg_b;
		logic        leg_b_given;
		logic [31:0] hypotenuse;
		logic        hypotenuse_given;
		logic [22:0] angle_opp_a;
		logic        angle_opp_a_given;
		logic [22:0] angle_opp_b;
		logic        angle_opp_b_given;
	} item_t;

	typedef struct packed {
		logic [31:0] out_leg_a;
		logic [31:0] out_leg_b;
		logic [31:0] out_hypotenuse;
		logic [22:0] out_angle_a;
		logic [22:0] out_angle_b;
		logic [1:0]  status;
	} result_t;

	// classified item handed from front to back
	typedef struct packed {
		mode_t       mode;
		logic        err;
		logic [31:0] leg;
		logic [31:0] leg2;
		logic [31:0] hyp;
		logic [22:0] ang;
	} cls_t;

	// item state carried along the back pipeline
	typedef struct packed {
		mode_t       mode;
		logic        err;
		logic [31:0] leg;
		logic [31:0] leg2;
		logic [31:0] hyp;
		logic [22:0] ang;
		logic [30:0] sn;
		logic [30:0] cs;
		logic [31:0] legx;
		logic        rsat;
		logic        sat1;
		logic        sat2;
		logic [31:0] ra;
		logic [31:0] rb;
		logic [31:0] rc;
		logic        vy0;
		logic        vx0;
	} work_t;

endpackage

@@ rtl/rts_front.sv @@
module rts_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  rts_pkg::item_t item,
	output logic          cls_valid,
	output rts_pkg::cls_t cls,
	input  logic          cls_pop
);
	import rts_pkg::*;

	localparam int QDEPTH = 4;
	localparam int QW = $clog2(QDEPTH);

	cls_t            cls_in;
	cls_t            mem_q [QDEPTH];
	logic [QW-1:0]   wr_q;
	logic [QW-1:0]   rd_q;
	logic [QW:0]     cnt_q;
	logic            do_push;
	logic            do_pop;

	// pick the first supplied pair and flag simple domain errors
	always_comb begin
		cls_in = '0;
		cls_in.mode = MODE_FEW;
		if (item.leg_a_given && item.leg_b_given) begin
			cls_in.mode = MODE_AB;
			cls_in.leg = item.leg_a;
			cls_in.leg2 = item.leg_b;
		end else if (item.leg_a_given && item.hypotenuse_given) begin
			cls_in.mode = MODE_AC;
			cls_in.leg = item.leg_a;
			cls_in.hyp = item.hypotenuse;
			cls_in.err = (item.hypotenuse == '0) || (item.leg_a > item.hypotenuse);
		end else if (item.leg_b_given && item.hypotenuse_given) begin
			cls_in.mode = MODE_BC;
			cls_in.leg = item.leg_b;
			cls_in.hyp = item.hypotenuse;
			cls_in.err = (item.hypotenuse == '0) || (item.leg_b > item.hypotenuse);
		end else if (item.leg_a_given && item.angle_opp_a_given) begin
			cls_in.mode = MODE_AA;
			cls_in.leg = item.leg_a;
			cls_in.ang = item.angle_opp_a;
			cls_in.err = item.angle_opp_a > RIGHT_Q16;
		end else if (item.leg_b_given && item.angle_opp_b_given) begin
			cls_in.mode = MODE_BB;
			cls_in.leg = item.leg_b;
			cls_in.ang = item.angle_opp_b;
			cls_in.err = item.angle_opp_b > RIGHT_Q16;
		end else if (item.hypotenuse_given && item.angle_opp_a_given) begin
			cls_in.mode = MODE_CA;
			cls_in.hyp = item.hypotenuse;
			cls_in.ang = item.angle_opp_a;
			cls_in.err = item.angle_opp_a > RIGHT_Q16;
		end else if (item.hypotenuse_given && item.angle_opp_b_given) begin
			cls_in.mode = MODE_CB;
			cls_in.hyp = item.hypotenuse;
			cls_in.ang = item.angle_opp_b;
			cls_in.err = item.angle_opp_b > RIGHT_Q16;
		end
	end

	// queue handshake
	assign full = (cnt_q == (QW+1)'(QDEPTH));
	assign cls_valid = (cnt_q != '0);
	assign cls = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = cls_pop && cls_valid;

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= cls_in;
	end

endmodule

@@ rtl/rts_back.sv @@
module rts_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             cls_valid,
	input  rts_pkg::cls_t    cls,
	output logic             cls_pop,
	output logic             res_valid,
	output rts_pkg::result_t res
);
	import rts_pkg::*;

	localparam int LAT = 2 * STEPS + 41;
	localparam logic signed [33:0] ONE_S = 34'sd1073741824;

	logic [LAT-1:0] vld_s;

	// rotation cordic stages
	work_t             rot_w_s [STEPS+1];
	logic signed [33:0] rot_x_s [STEPS+1];
	logic signed [33:0] rot_y_s [STEPS+1];
	logic signed [33:0] rot_z_s [STEPS+1];

	work_t       w_in;
	work_t       sc_w;
	work_t       b1_w_s;
	work_t       b2_w_s;
	logic [62:0] m1_s2;
	logic [62:0] m2_s2;
	work_t       b3_in;
	work_t       b3_w_s;
	logic [63:0] p_s3;
	logic [63:0] q_s3;
	logic [61:0] n2_s3;
	logic [31:0] u3;
	logic [31:0] v3;
	logic [64:0] sum4;
	work_t       d0_in;

	// root and divide stages
	work_t       div_w_s [33];
	logic [63:0] rem_s [33];
	logic [31:0] root_s [33];
	logic [61:0] n1_s [33];
	logic [61:0] n2_s [33];
	logic [31:0] q1_s [33];
	logic [31:0] q2_s [33];

	work_t       rw;
	logic [31:0] rvx;
	logic [31:0] q1_sat;
	logic [31:0] q2_sat;
	work_t       r_w_s;
	logic [31:0] vy_s;
	logic [31:0] vx_s;
	work_t       v1_in;
	work_t       v1_w_s;
	logic [31:0] vy_s1;
	logic [31:0] vx_s1;
	logic [5:0]  k_s1;
	logic [31:0] lead_m;
	logic [4:0]  lead_pos;

	// vectoring cordic stages
	work_t             vec_w_s [STEPS+1];
	logic signed [44:0] vec_x_s [STEPS+1];
	logic signed [44:0] vec_y_s [STEPS+1];
	logic signed [33:0] vec_z_s [STEPS+1];

	work_t       fw;
	logic [33:0] zc;
	logic [33:0] zr;
	logic [22:0] vang;
	result_t     res_c;

	assign cls_pop = en && cls_valid;
	assign res_valid = vld_s[LAT-1];

	// valid bits advance with the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s <= '0;
		else if (en) vld_s <= {vld_s[LAT-2:0], cls_valid};
	end

	// load classified item
	always_comb begin
		w_in = '0;
		w_in.mode = cls.mode;
		w_in.err = cls.err;
		w_in.leg = cls.leg;
		w_in.leg2 = cls.leg2;
		w_in.hyp = cls.hyp;
		w_in.ang = cls.ang;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_w_s[0] <= w_in;
			rot_x_s[0] <= GAIN_Q30;
			rot_y_s[0] <= '0;
			rot_z_s[0] <= $signed({3'b0, cls.ang, 8'b0});
		end
	end

	// sine and cosine, one micro-rotation per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				rot_w_s[i+1] <= rot_w_s[i];
				if (!rot_z_s[i][33]) begin
					rot_x_s[i+1] <= rot_x_s[i] - (rot_y_s[i] >>> i);
					rot_y_s[i+1] <= rot_y_s[i] + (rot_x_s[i] >>> i);
					rot_z_s[i+1] <= rot_z_s[i] - $signed({4'b0, STEP_DEG[i]});
				end else begin
					rot_x_s[i+1] <= rot_x_s[i] + (rot_y_s[i] >>> i);
					rot_y_s[i+1] <= rot_y_s[i] - (rot_x_s[i] >>> i);
					rot_z_s[i+1] <= rot_z_s[i] + $signed({4'b0, STEP_DEG[i]});
				end
			end
		end
	end

	// clamp sine and cosine, exact values at zero and right angle
	always_comb begin
		sc_w = rot_w_s[STEPS];
		if (rot_x_s[STEPS] < 0) sc_w.cs = '0;
		else if (rot_x_s[STEPS] > ONE_S) sc_w.cs = ONE_Q30;
		else sc_w.cs = rot_x_s[STEPS][30:0];
		if (rot_y_s[STEPS] < 0) sc_w.sn = '0;
		else if (rot_y_s[STEPS] > ONE_S) sc_w.sn = ONE_Q30;
		else sc_w.sn = rot_y_s[STEPS][30:0];
		if (rot_w_s[STEPS].ang == '0) begin
			sc_w.sn = '0;
			sc_w.cs = ONE_Q30;
		end else if (rot_w_s[STEPS].ang == RIGHT_Q16) begin
			sc_w.sn = ONE_Q30;
			sc_w.cs = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) b1_w_s <= sc_w;
	end

	// leg times cosine, hypotenuse times sine
	always_ff @(posedge clk) begin
		if (en) begin
			b2_w_s <= b1_w_s;
			m1_s2 <= {31'b0, b1_w_s.leg} * {32'b0, b1_w_s.cs};
			m2_s2 <= {31'b0, b1_w_s.hyp} * {32'b0, b1_w_s.sn};
		end
	end

	// square operands per mode
	always_comb begin
		case (b2_w_s.mode)
			MODE_AB: begin
				u3 = b2_w_s.leg;
				v3 = b2_w_s.leg2;
			end
			MODE_CA, MODE_CB: begin
				u3 = b2_w_s.hyp;
				v3 = m2_s2[61:30];
			end
			default: begin
				u3 = b2_w_s.hyp;
				v3 = b2_w_s.leg;
			end
		endcase
	end

	// leg from hypotenuse times sine
	always_comb begin
		b3_in = b2_w_s;
		b3_in.legx = m2_s2[61:30];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b3_w_s <= b3_in;
			p_s3 <= {32'b0, u3} * {32'b0, u3};
			q_s3 <= {32'b0, v3} * {32'b0, v3};
			n2_s3 <= m1_s2[61:0];
		end
	end

	// radicand and divider setup with saturation checks
	assign sum4 = {1'b0, p_s3} + {1'b0, q_s3};

	always_comb begin
		d0_in = b3_w_s;
		d0_in.sat1 = {1'b0, b3_w_s.leg[31:2]} >= b3_w_s.sn;
		d0_in.sat2 = {1'b0, n2_s3[61:32]} >= b3_w_s.sn;
		d0_in.rsat = (b3_w_s.mode == MODE_AB) && sum4[64];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_w_s[0] <= d0_in;
			if (b3_w_s.mode == MODE_AB) rem_s[0] <= sum4[63:0];
			else rem_s[0] <= p_s3 - q_s3;
			root_s[0] <= '0;
			n1_s[0] <= {b3_w_s.leg, 30'b0};
			n2_s[0] <= n2_s3;
			q1_s[0] <= '0;
			q2_s[0] <= '0;
		end
	end

	// one root bit and one quotient bit of each division per stage
	for (genvar j = 0; j < 32; j++) begin : g_div
		localparam int B = 31 - j;
		logic [65:0] trial;
		logic [62:0] dsh;
		assign trial = ({34'b0, root_s[j]} << (B + 1)) + (66'd1 << (2 * B));
		assign dsh = {32'b0, div_w_s[j].sn} << B;
		always_ff @(posedge clk) begin
			if (en) begin
				div_w_s[j+1] <= div_w_s[j];
				if ({2'b0, rem_s[j]} >= trial) begin
					rem_s[j+1] <= rem_s[j] - trial[63:0];
					root_s[j+1] <= root_s[j] | (32'd1 << B);
				end else begin
					rem_s[j+1] <= rem_s[j];
					root_s[j+1] <= root_s[j];
				end
				if ({1'b0, n1_s[j]} >= dsh) begin
					n1_s[j+1] <= n1_s[j] - dsh[61:0];
					q1_s[j+1] <= q1_s[j] | (32'd1 << B);
				end else begin
					n1_s[j+1] <= n1_s[j];
					q1_s[j+1] <= q1_s[j];
				end
				if ({1'b0, n2_s[j]} >= dsh) begin
					n2_s[j+1] <= n2_s[j] - dsh[61:0];
					q2_s[j+1] <= q2_s[j] | (32'd1 << B);
				end else begin
					n2_s[j+1] <= n2_s[j];
					q2_s[j+1] <= q2_s[j];
				end
			end
		end
	end

	// resolve sides per mode and pick vectoring inputs
	assign q1_sat = div_w_s[32].sat1 ? 32'hFFFF_FFFF : q1_s[32];
	assign q2_sat = div_w_s[32].sat2 ? 32'hFFFF_FFFF : q2_s[32];

	always_comb begin
		rw = div_w_s[32];
		rvx = root_s[32];
		rw.ra = '0;
		rw.rb = '0;
		rw.rc = '0;
		case (rw.mode)
			MODE_AB: begin
				rw.ra = rw.leg;
				rw.rb = rw.leg2;
				rw.rc = rw.rsat ? 32'hFFFF_FFFF : root_s[32];
				rvx = rw.leg2;
			end
			MODE_AC: begin
				rw.ra = rw.leg;
				rw.rb = root_s[32];
				rw.rc = rw.hyp;
			end
			MODE_BC: begin
				rw.rb = rw.leg;
				rw.ra = root_s[32];
				rw.rc = rw.hyp;
			end
			MODE_AA: begin
				rw.ra = rw.leg;
				rw.rc = q1_sat;
				rw.rb = q2_sat;
				rw.err = rw.err || (rw.sn == '0);
			end
			MODE_BB: begin
				rw.rb = rw.leg;
				rw.rc = q1_sat;
				rw.ra = q2_sat;
				rw.err = rw.err || (rw.sn == '0);
			end
			MODE_CA: begin
				rw.ra = rw.legx;
				rw.rb = root_s[32];
				rw.rc = rw.hyp;
			end
			MODE_CB: begin
				rw.rb = rw.legx;
				rw.ra = root_s[32];
				rw.rc = rw.hyp;
			end
			default: begin
				rw.ra = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_w_s <= rw;
			vy_s <= rw.leg;
			vx_s <= rvx;
		end
	end

	// leading one search for normalization
	assign lead_m = vy_s | vx_s;

	always_comb begin
		lead_pos = '0;
		for (int i = 0; i < 32; i++) begin
			if (lead_m[i]) lead_pos = 5'(i);
		end
	end

	// zero operand flags
	always_comb begin
		v1_in = r_w_s;
		v1_in.vy0 = (vy_s == '0);
		v1_in.vx0 = (vx_s == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v1_w_s <= v1_in;
			vy_s1 <= vy_s;
			vx_s1 <= vx_s;
			k_s1 <= 6'd40 - {1'b0, lead_pos};
		end
	end

	// normalizing shift
	always_ff @(posedge clk) begin
		if (en) begin
			vec_w_s[0] <= v1_w_s;
			vec_x_s[0] <= $signed({13'b0, vx_s1} << k_s1);
			vec_y_s[0] <= $signed({13'b0, vy_s1} << k_s1);
			vec_z_s[0] <= '0;
		end
	end

	// atan2, one micro-rotation per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en) begin
				vec_w_s[i+1] <= vec_w_s[i];
				if (!vec_y_s[i][44]) begin
					vec_x_s[i+1] <= vec_x_s[i] + (vec_y_s[i] >>> i);
					vec_y_s[i+1] <= vec_y_s[i] - (vec_x_s[i] >>> i);
					vec_z_s[i+1] <= vec_z_s[i] + $signed({4'b0, STEP_DEG[i]});
				end else begin
					vec_x_s[i+1] <= vec_x_s[i] - (vec_y_s[i] >>> i);
					vec_y_s[i+1] <= vec_y_s[i] + (vec_x_s[i] >>> i);
					vec_z_s[i+1] <= vec_z_s[i] - $signed({4'b0, STEP_DEG[i]});
				end
			end
		end
	end

	// round angle, assign angles per mode, build result
	assign fw = vec_w_s[STEPS];
	assign zc = vec_z_s[STEPS][33] ? 34'd0 : vec_z_s[STEPS];
	assign zr = zc + 34'd128;

	always_comb begin
		if (fw.vy0) vang = '0;
		else if (fw.vx0) vang = RIGHT_Q16;
		else if (zr[33:8] > {3'b0, RIGHT_Q16}) vang = RIGHT_Q16;
		else vang = zr[30:8];
	end

	always_comb begin
		res_c = '0;
		res_c.out_leg_a = fw.ra;
		res_c.out_leg_b = fw.rb;
		res_c.out_hypotenuse = fw.rc;
		res_c.status = ST_OK;
		case (fw.mode)
			MODE_AB, MODE_AC: begin
				res_c.out_angle_a = vang;
				res_c.out_angle_b = RIGHT_Q16 - vang;
			end
			MODE_BC: begin
				res_c.out_angle_b = vang;
				res_c.out_angle_a = RIGHT_Q16 - vang;
			end
			MODE_AA, MODE_CA: begin
				res_c.out_angle_a = fw.ang;
				res_c.out_angle_b = RIGHT_Q16 - fw.ang;
			end
			MODE_BB, MODE_CB: begin
				res_c.out_angle_b = fw.ang;
				res_c.out_angle_a = RIGHT_Q16 - fw.ang;
			end
			default: begin
				res_c.status = ST_FEW;
			end
		endcase
		if (fw.mode == MODE_FEW) begin
			res_c = '0;
			res_c.status = ST_FEW;
		end else if (fw.err) begin
			res_c = '0;
			res_c.status = ST_DOMAIN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) res <= res_c;
	end

endmodule

@@ rtl/right_triangle_solver_unit.sv @@
// Right triangle solver. Items enter on a queue-style port: an item is taken
// at a clock edge with push high and full low. Each item gives legs a and b,
// the hypotenuse and the two acute angles, each with a given flag; the first
// supplied pair (ab, ac, bc, aA, bB, cA, cB) selects the formulas.
// Results leave the same way: while empty is low the oldest result sits on
// result, and it is taken at an edge with pop high.
// The front classifies items into a four-entry queue; the back is a fixed
// pipeline of 97 stages (28-stage sine/cosine cordic, two multiply stages,
// 32-stage square root and dividers side by side, 28-stage atan2 cordic).
// One item per cycle is sustained, set by the fully pipelined back end, while
// the two-entry output queue has room.
// When the receiver stops popping, a two-entry output queue fills and the
// whole back pipeline holds; the front queue then fills and full rises.
// Reset clears all valid bits and queue pointers; no item is in flight after.
module right_triangle_solver_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  rts_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output rts_pkg::result_t result
);
	import rts_pkg::*;

	cls_t    cls;
	logic    cls_valid;
	logic    cls_pop;
	logic    en;
	logic    res_valid;
	result_t res;

	result_t oq_q [2];
	logic    wr_q;
	logic    rd_q;
	logic [1:0] cnt_q;
	logic    oq_push;
	logic    oq_pop;

	// front: classify and queue
	rts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cls_valid (cls_valid),
		.cls       (cls),
		.cls_pop   (cls_pop)
	);

	// back: solve pipeline
	rts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cls_valid (cls_valid),
		.cls       (cls),
		.cls_pop   (cls_pop),
		.res_valid (res_valid),
		.res       (res)
	);

	// output queue handshake
	assign en = (cnt_q != 2'd2);
	assign oq_push = en && res_valid;
	assign empty = (cnt_q == 2'd0);
	assign oq_pop = pop && !empty;
	assign result = oq_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (oq_push) wr_q <= ~wr_q;
			if (oq_pop) rd_q <= ~rd_q;
			case ({oq_push, oq_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// output queue storage
	always_ff @(posedge clk) begin
		if (oq_push) oq_q[wr_q] <= res;
	end

endmodule

@@ verif/tb_right_triangle_solver_unit.sv @@
`timescale 1ns / 100ps

module tb_right_triangle_solver_unit;
	import rts_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_ITEMS = 600;

	logic    clk;
	logic    arst_n;
	logic    push;
	logic    full;
	item_t   item;
	logic    empty;
	logic    pop;
	result_t result;

	// directed row: item plus an optional hand-written answer
	typedef struct {
		item_t   it;
		bit      fixed;
		result_t want;
	} row_t;

	result_t solutions_due[$];
	row_t    directed[$];
	int      cycles;
	int      errors;
	bit      calm;

	right_triangle_solver_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// floor square root of a 64-bit value
	function automatic logic [31:0] floor_root(logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[31:0];
	endfunction

	function automatic logic [31:0] clip32(logic [63:0] v);
		return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
	endfunction

	// atan2 in degrees q7.16 for nonnegative y and x
	function automatic logic [22:0] bearing(logic [31:0] y, logic [31:0] x);
		longint xs, ys, z, nx;
		logic [63:0] r;
		if (y == 0) return 23'd0;
		if (x == 0) return RIGHT_Q16;
		xs = longint'(x);
		ys = longint'(y);
		z = 0;
		while (xs < 64'sd1099511627776 && ys < 64'sd1099511627776) begin
			xs = xs * 2;
			ys = ys * 2;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (ys >= 0) begin
				nx = xs + (ys >>> i);
				ys = ys - (xs >>> i);
				z = z + longint'(STEP_DEG[i]);
			end else begin
				nx = xs - (ys >>> i);
				ys = ys + (xs >>> i);
				z = z - longint'(STEP_DEG[i]);
			end
			xs = nx;
		end
		if (z < 0) z = 0;
		r = (z + 128) >> 8;
		return (r > RIGHT_Q16) ? RIGHT_Q16 : r[22:0];
	endfunction

	// sine and cosine q30 of an angle up to 90 degrees
	function automatic void sine_cosine(input logic [22:0] ang, output longint s,
			output longint c);
		longint x, y, z, nx;
		if (ang == 0) begin
			s = 0;
			c = longint'(ONE_Q30);
			return;
		end
		if (ang == RIGHT_Q16) begin
			s = longint'(ONE_Q30);
			c = 0;
			return;
		end
		x = longint'(GAIN_Q30);
		y = 0;
		z = longint'(ang) * 256;
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - longint'(STEP_DEG[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + longint'(STEP_DEG[i]);
			end
			x = nx;
		end
		if (x < 0) x = 0;
		if (y < 0) y = 0;
		if (x > longint'(ONE_Q30)) x = longint'(ONE_Q30);
		if (y > longint'(ONE_Q30)) y = longint'(ONE_Q30);
		s = y;
		c = x;
	endfunction

	// expected triangle for one item
	function automatic result_t solve_triangle(item_t t);
		result_t r;
		logic [63:0] sa, sb, lg, sn_u, cs_u;
		logic [64:0] sum;
		longint sn, cs;
		bit ha, hb, hc, hA, hB, ok;
		r = '0;
		ha = t.leg_a_given;
		hb = t.leg_b_given;
		hc = t.hypotenuse_given;
		hA = t.angle_opp_a_given;
		hB = t.angle_opp_b_given;
		ok = 1'b1;
		r.status = ST_OK;
		if (ha && hb) begin
			sa = 64'(t.leg_a) * 64'(t.leg_a);
			sb = 64'(t.leg_b) * 64'(t.leg_b);
			sum = 65'(sa) + 65'(sb);
			r.out_leg_a = t.leg_a;
			r.out_leg_b = t.leg_b;
			r.out_hypotenuse = sum[64] ? 32'hFFFFFFFF : floor_root(sum[63:0]);
			r.out_angle_a = bearing(t.leg_a, t.leg_b);
			r.out_angle_b = RIGHT_Q16 - r.out_angle_a;
		end else if ((ha && hc) || (hb && hc)) begin
			// one leg with the hypotenuse; a is preferred over b
			lg = ha ? 64'(t.leg_a) : 64'(t.leg_b);
			ok = t.hypotenuse != 0 && lg <= 64'(t.hypotenuse);
			if (ok) begin
				r.out_hypotenuse = t.hypotenuse;
				sa = 64'(floor_root(64'(t.hypotenuse) * 64'(t.hypotenuse) - lg * lg));
				if (ha) begin
					r.out_leg_a = t.leg_a;
					r.out_leg_b = sa[31:0];
					r.out_angle_a = bearing(t.leg_a, sa[31:0]);
					r.out_angle_b = RIGHT_Q16 - r.out_angle_a;
				end else begin
					r.out_leg_b = t.leg_b;
					r.out_leg_a = sa[31:0];
					r.out_angle_b = bearing(t.leg_b, sa[31:0]);
					r.out_angle_a = RIGHT_Q16 - r.out_angle_b;
				end
			end
		end else if ((ha && hA) || (hb && hB)) begin
			// leg over the sine of its opposite angle
			lg = (ha && hA) ? 64'(t.leg_a) : 64'(t.leg_b);
			r.out_angle_a = (ha && hA) ? t.angle_opp_a : t.angle_opp_b;
			ok = r.out_angle_a <= RIGHT_Q16;
			if (ok) begin
				sine_cosine(r.out_angle_a, sn, cs);
				ok = sn != 0;
			end
			if (ok) begin
				sn_u = sn;
				cs_u = cs;
				r.out_hypotenuse = clip32((lg << 30) / sn_u);
				sa = 64'(clip32((lg * cs_u) / sn_u));
				r.out_angle_b = RIGHT_Q16 - r.out_angle_a;
				if (ha && hA) begin
					r.out_leg_a = lg[31:0];
					r.out_leg_b = sa[31:0];
				end else begin
					r.out_leg_b = lg[31:0];
					r.out_leg_a = sa[31:0];
					{r.out_angle_a, r.out_angle_b} = {r.out_angle_b, r.out_angle_a};
				end
			end
		end else if (hc && (hA || hB)) begin
			// hypotenuse times the sine of the angle opposite the wanted leg
			r.out_angle_a = hA ? t.angle_opp_a : t.angle_opp_b;
			ok = r.out_angle_a <= RIGHT_Q16;
			if (ok) begin
				sine_cosine(r.out_angle_a, sn, cs);
				sn_u = sn;
				lg = (64'(t.hypotenuse) * sn_u) >> 30;
				sa = 64'(floor_root(64'(t.hypotenuse) * 64'(t.hypotenuse) - lg * lg));
				r.out_hypotenuse = t.hypotenuse;
				r.out_angle_b = RIGHT_Q16 - r.out_angle_a;
				if (hA) begin
					r.out_leg_a = lg[31:0];
					r.out_leg_b = sa[31:0];
				end else begin
					r.out_leg_b = lg[31:0];
					r.out_leg_a = sa[31:0];
					{r.out_angle_a, r.out_angle_b} = {r.out_angle_b, r.out_angle_a};
				end
			end
		end else begin
			r = '0;
			r.status = ST_FEW;
			return r;
		end
		if (!ok) begin
			r = '0;
			r.status = ST_DOMAIN;
		end
		return r;
	endfunction

	function automatic item_t pack_item(logic [31:0] a, bit ha, logic [31:0] b, bit hb,
			logic [31:0] c, bit hc, logic [22:0] aa, bit haa, logic [22:0] bb, bit hbb);
		item_t t;
		t = '{a, ha, b, hb, c, hc, aa, haa, bb, hbb};
		return t;
	endfunction

	function automatic logic [31:0] rand_len();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom >> $urandom_range(31);
			default: return $urandom_range(32'h00FFFFFF);
		endcase
	endfunction

	function automatic logic [22:0] rand_ang();
		if ($urandom_range(9) == 0) return 23'($urandom);
		if ($urandom_range(19) == 0) return $urandom_range(1) ? RIGHT_Q16 : 23'd0;
		return 23'($urandom_range(RIGHT_Q16));
	endfunction

	// random item aimed at one pair, other flags as noise
	function automatic item_t rand_item();
		item_t t;
		logic [31:0] tmp;
		int pick;
		t = pack_item(rand_len(), 0, rand_len(), 0, rand_len(), 0, rand_ang(), 0,
			rand_ang(), 0);
		t.leg_a_given = ($urandom_range(3) == 0);
		t.leg_b_given = ($urandom_range(3) == 0);
		t.hypotenuse_given = ($urandom_range(3) == 0);
		t.angle_opp_a_given = ($urandom_range(3) == 0);
		t.angle_opp_b_given = ($urandom_range(3) == 0);
		pick = $urandom_range(7);
		case (pick)
			0: {t.leg_a_given, t.leg_b_given} = 2'b11;
			1: {t.leg_a_given, t.hypotenuse_given} = 2'b11;
			2: {t.leg_b_given, t.hypotenuse_given} = 2'b11;
			3: {t.leg_a_given, t.angle_opp_a_given} = 2'b11;
			4: {t.leg_b_given, t.angle_opp_b_given} = 2'b11;
			5: {t.hypotenuse_given, t.angle_opp_a_given} = 2'b11;
			6: {t.hypotenuse_given, t.angle_opp_b_given} = 2'b11;
			default: ;
		endcase
		// mostly keep the hypotenuse no shorter than the given leg
		if ($urandom_range(4) != 0) begin
			if (t.leg_a > t.hypotenuse) begin
				tmp = t.leg_a;
				t.leg_a = t.hypotenuse;
				t.hypotenuse = tmp;
			end
			if (t.leg_b > t.hypotenuse) begin
				tmp = t.leg_b;
				t.leg_b = t.hypotenuse;
				t.hypotenuse = tmp;
			end
		end
		return t;
	endfunction

	// hand one item over, with random idle cycles first
	task automatic send_item(item_t t);
		while (!calm && $urandom_range(99) < 30) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= t;
		do @(posedge clk); while (full);
		solutions_due.push_back(solve_triangle(t));
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// receiver idling
	always @(posedge clk) begin
		pop <= calm ? 1'b1 : ($urandom_range(99) >= 30);
	end

	// compare each popped result with the oldest expected one
	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (solutions_due.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $time, result);
				errors++;
			end else begin
				want = solutions_due.pop_front();
				check_field("out_leg_a", want.out_leg_a, result.out_leg_a);
				check_field("out_leg_b", want.out_leg_b, result.out_leg_b);
				check_field("out_hypotenuse", want.out_hypotenuse, result.out_hypotenuse);
				check_field("out_angle_a", 32'(want.out_angle_a), 32'(result.out_angle_a));
				check_field("out_angle_b", 32'(want.out_angle_b), 32'(result.out_angle_b));
				check_field("status", 32'(want.status), 32'(result.status));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("right_triangle_solver_unit verification failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		row_t r;
		calm = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		arst_n = 1'b0;

		// directed rows; fixed answers where they are obvious
		directed.push_back('{pack_item(5, 0, 7, 0, 9, 0, 100, 0, 200, 0), 1,
			'{0, 0, 0, 0, 0, ST_FEW}});
		directed.push_back('{pack_item(0, 1, 0, 1, 0, 0, 0, 0, 0, 0), 1,
			'{0, 0, 0, 0, RIGHT_Q16, ST_OK}});
		directed.push_back('{pack_item(32'hFFFFFFFF, 1, 32'hFFFFFFFF, 1, 0, 0, 0, 0, 0, 0),
			0, '0});
		directed.push_back('{pack_item(32'h10000, 1, 0, 1, 0, 0, 0, 0, 0, 0), 1,
			'{32'h10000, 0, 32'h10000, RIGHT_Q16, 0, ST_OK}});
		directed.push_back('{pack_item(32'h30000, 1, 32'h40000, 1, 0, 0, 0, 0, 0, 0),
			0, '0});
		directed.push_back('{pack_item(5, 1, 0, 0, 0, 1, 0, 0, 0, 0), 1,
			'{0, 0, 0, 0, 0, ST_DOMAIN}});
		directed.push_back('{pack_item(32'h20000, 1, 0, 0, 32'h10000, 1, 0, 0, 0, 0), 1,
			'{0, 0, 0, 0, 0, ST_DOMAIN}});
		directed.push_back('{pack_item(32'hFFFFFFFF, 1, 0, 0, 32'hFFFFFFFF, 1, 0, 0, 0, 0),
			0, '0});
		directed.push_back('{pack_item(0, 0, 32'h30000, 1, 32'h50000, 1, 0, 0, 0, 0),
			0, '0});
		directed.push_back('{pack_item(0, 0, 32'h60000, 1, 32'h50000, 1, 0, 0, 0, 0), 1,
			'{0, 0, 0, 0, 0, ST_DOMAIN}});
		directed.push_back('{pack_item(32'h10000, 1, 0, 0, 0, 0, 0, 1, 0, 0), 1,
			'{0, 0, 0, 0, 0, ST_DOMAIN}});
		directed.push_back('{pack_item(32'h10000, 1, 0, 0, 0, 0, RIGHT_Q16, 1, 0, 0),
			0, '0});
		directed.push_back('{pack_item(32'h10000, 1, 0, 0, 0, 0, RIGHT_Q16 + 23'd1, 1, 0,
			0), 1, '{0, 0, 0, 0, 0, ST_DOMAIN}});
		directed.push_back('{pack_item(0, 0, 32'hFFFFFFFF, 1, 0, 0, 0, 0, 23'd1966080, 1),
			0, '0});
		directed.push_back('{pack_item(0, 0, 32'h10000, 1, 0, 0, 0, 0, 23'h7FFFFF, 1), 1,
			'{0, 0, 0, 0, 0, ST_DOMAIN}});
		directed.push_back('{pack_item(0, 0, 0, 0, 32'hFFFFFFFF, 1, 0, 1, 0, 0), 0, '0});
		directed.push_back('{pack_item(0, 0, 0, 0, 32'h50000, 1, RIGHT_Q16, 1, 0, 0), 0, '0});
		directed.push_back('{pack_item(0, 0, 0, 0, 32'h50000, 1, 23'h7FFFFF, 1, 0, 0), 1,
			'{0, 0, 0, 0, 0, ST_DOMAIN}});
		directed.push_back('{pack_item(0, 0, 0, 0, 32'h1234567, 1, 0, 0, 23'd2949120, 1),
			0, '0});
		directed.push_back('{pack_item(32'hFFFFFFFF, 1, 32'hFFFFFFFF, 1, 32'hFFFFFFFF, 1,
			23'h7FFFFF, 1, 23'h7FFFFF, 1), 0, '0});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (directed[i]) begin
			r = directed[i];
			send_item(r.it);
			if (r.fixed) solutions_due[$] = r.want;
		end

		// random part with a calm stretch and one full drain
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 200) calm = 1'b1;
			if (n == 320) calm = 1'b0;
			if (n == 400) begin
				push <= 1'b0;
				while (solutions_due.size() != 0) @(posedge clk);
			end
			send_item(rand_item());
		end
		push <= 1'b0;

		while (solutions_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("right_triangle_solver_unit verification clean");
		else
			$display("right_triangle_solver_unit verification failed");
		$finish;
	end

endmodule
